/* rtl/core/gbs_pkg.sv */
// Shared types and constants of the grid bilinear sampler.
// No dependencies; every other file of the block but gbs_check imports it.
package gbs_pkg;

  localparam int IDX_W       = 10;
  localparam int MAG_W       = 32;
  localparam int STEP_W      = 31;
  localparam int QUO_W       = 48;
  localparam int DIV_STAGES  = QUO_W;
  localparam int FRAC_W      = 17;
  localparam int CNT_W       = 11;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    CFG_X_ORIGIN  = 3'd0,
    CFG_X_SPACING = 3'd1,
    CFG_Y_ORIGIN  = 3'd2,
    CFG_Y_SPACING = 3'd3,
    CFG_COLUMNS   = 3'd4,
    CFG_ROWS      = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] x_origin;
    logic [30:0]        x_spacing;
    logic signed [31:0] y_origin;
    logic [30:0]        y_spacing;
    logic [6:0]         columns_used;
    logic [6:0]         rows_used;
  } gbs_cfg_t;

  typedef struct packed {
    logic                     cmd;
    logic [5:0]               col;
    logic [5:0]               row;
    logic [15:0]              height;
    logic [IDX_W-1:0]         ix;
    logic [IDX_W-1:0]         iy;
    logic signed [FRAC_W-1:0] tx;
    logic signed [FRAC_W-1:0] ty;
  } q_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [FRAC_W-1:0] frac;
  } loc_t;

  function automatic loc_t locate(input logic [QUO_W-1:0] q, input logic neg,
                                  input logic [CNT_W-1:0] n);
    loc_t             res;
    logic [31:0]      imag;
    logic [15:0]      f;
    logic [CNT_W-1:0] nm1;
    logic [CNT_W-1:0] nm2;
    imag = q[QUO_W-1:16];
    f    = q[15:0];
    nm1  = n - CNT_W'(1);
    nm2  = n - CNT_W'(2);
    if (neg) begin
      res.idx  = '0;
      res.frac = (imag == 32'd0) ? -$signed({1'b0, f}) : '0;
    end else if (imag >= {{(32-CNT_W){1'b0}}, nm1}) begin
      res.idx  = nm2[IDX_W-1:0];
      res.frac = '0;
    end else begin
      res.idx  = imag[IDX_W-1:0];
      res.frac = $signed({1'b0, f});
    end
    return res;
  endfunction

endpackage

/* rtl/core/grid_bilinear_sampler.sv */
// Top level of the grid bilinear sampler: configuration registers, front end,
// queue and back end. Depends on gbs_pkg, gbs_front, gbs_fifo and gbs_back.
//
//   channel  handshake            payload
//   input    start / busy         in_command in_column in_row in_height
//                                 in_x_coord in_y_coord
//   result   out_valid strobe     out_value
//   config   cfg_valid/cfg_ready  cfg_index cfg_data
//
// One command per cycle while busy is low; each query gives one result on out_value.
// The front end divides with two 48-stage pipelined dividers, one quotient bit each.
// Four parity banks let all corners of a query be read in the same cycle.
// Reset clears control state and loads the default configuration; grid contents are undefined until written.
// Results cannot be held off; the queue only fills if the back end stops.
module grid_bilinear_sampler #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [5:0]         in_column,
  input  logic [5:0]         in_row,
  input  logic [15:0]        in_height,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import gbs_pkg::*;

  gbs_cfg_t cfg_r;
  logic     push;
  q_item_t  push_item;
  logic     full;
  logic     pop;
  logic     q_valid;
  q_item_t  head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin     <= '0;
      cfg_r.x_spacing    <= 31'd65536;
      cfg_r.y_origin     <= '0;
      cfg_r.y_spacing    <= 31'd65536;
      cfg_r.columns_used <= 7'd2;
      cfg_r.rows_used    <= 7'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_X_ORIGIN:  cfg_r.x_origin     <= cfg_data;
        CFG_X_SPACING: cfg_r.x_spacing    <= cfg_data[30:0];
        CFG_Y_ORIGIN:  cfg_r.y_origin     <= cfg_data;
        CFG_Y_SPACING: cfg_r.y_spacing    <= cfg_data[30:0];
        CFG_COLUMNS:   cfg_r.columns_used <= cfg_data[6:0];
        CFG_ROWS:      cfg_r.rows_used    <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  gbs_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_column(in_column), .in_row(in_row),
    .in_height(in_height), .in_x_coord(in_x_coord), .in_y_coord(in_y_coord),
    .cfg(cfg_r), .full(full), .push(push), .push_item(push_item)
  );

  gbs_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item), .full(full),
    .pop(pop), .valid(q_valid), .head(head)
  );

  gbs_back #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk(clk), .rst_n(rst_n), .valid(q_valid), .item(head), .pop(pop),
    .out_valid(out_valid), .out_value(out_value)
  );

endmodule

/* rtl/core/gbs_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on gbs_pkg for widths.
module gbs_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [gbs_pkg::MAG_W-1:0]  mag,
  input  logic [gbs_pkg::STEP_W-1:0] step,
  output logic [gbs_pkg::QUO_W-1:0]  quo
);
  import gbs_pkg::*;

  logic [STEP_W-1:0] rem_r [DIV_STAGES];
  logic [QUO_W-1:0]  dvd_r [DIV_STAGES];
  logic [QUO_W-1:0]  quo_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [STEP_W-1:0] rem_in;
    logic [QUO_W-1:0]  dvd_in;
    logic [QUO_W-1:0]  quo_in;
    logic [STEP_W:0]   trial;
    logic [STEP_W:0]   diff;
    logic              ge;
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = {mag, 16'b0};
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign dvd_in = dvd_r[s-1];
      assign quo_in = quo_r[s-1];
    end
    assign trial = {rem_in, dvd_in[QUO_W-1]};
    assign ge    = trial >= {1'b0, step};
    assign diff  = trial - {1'b0, step};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
        dvd_r[s] <= {dvd_in[QUO_W-2:0], 1'b0};
        quo_r[s] <= {quo_in[QUO_W-2:0], ge};
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

/* rtl/core/gbs_front.sv */
// Front end: accepts commands, forms axis offsets, divides by the spacing
// and clamps index and fraction. Depends on gbs_pkg and gbs_div.
module gbs_front #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [5:0]         in_column,
  input  logic [5:0]         in_row,
  input  logic [15:0]        in_height,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  input  gbs_pkg::gbs_cfg_t  cfg,
  input  logic               full,
  output logic               push,
  output gbs_pkg::q_item_t   push_item
);
  import gbs_pkg::*;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [15:0] height;
    logic        negx;
    logic        negy;
  } side_t;

  logic                  en;
  logic signed [32:0]    dx;
  logic signed [32:0]    dy;
  logic [32:0]           adx;
  logic [32:0]           ady;
  logic [STEP_W-1:0]     stepx;
  logic [STEP_W-1:0]     stepy;
  logic [CNT_W-1:0]      nx;
  logic [CNT_W-1:0]      ny;
  logic [QUO_W-1:0]      quo_x;
  logic [QUO_W-1:0]      quo_y;
  loc_t                  locx;
  loc_t                  locy;

  logic                  s0_valid_r;
  side_t                 s0_side_r;
  logic [MAG_W-1:0]      magx_r;
  logic [MAG_W-1:0]      magy_r;
  logic [DIV_STAGES-1:0] vld_r;
  side_t                 side_r [DIV_STAGES];
  logic                  p_valid_r;
  q_item_t               p_item_r;

  assign en   = !p_valid_r || !full;
  assign busy = !en;
  assign push = p_valid_r && !full;
  assign push_item = p_item_r;

  assign dx  = $signed({in_x_coord[31], in_x_coord}) - $signed({cfg.x_origin[31], cfg.x_origin});
  assign dy  = $signed({in_y_coord[31], in_y_coord}) - $signed({cfg.y_origin[31], cfg.y_origin});
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);

  assign stepx = (cfg.x_spacing == '0) ? STEP_W'(1) : cfg.x_spacing;
  assign stepy = (cfg.y_spacing == '0) ? STEP_W'(1) : cfg.y_spacing;

  always_comb begin
    if (cfg.columns_used < 7'd2) begin
      nx = CNT_W'(2);
    end else if ({{(CNT_W-7){1'b0}}, cfg.columns_used} > CNT_W'(MAX_COLUMNS)) begin
      nx = CNT_W'(MAX_COLUMNS);
    end else begin
      nx = {{(CNT_W-7){1'b0}}, cfg.columns_used};
    end
    if (cfg.rows_used < 7'd2) begin
      ny = CNT_W'(2);
    end else if ({{(CNT_W-7){1'b0}}, cfg.rows_used} > CNT_W'(MAX_ROWS)) begin
      ny = CNT_W'(MAX_ROWS);
    end else begin
      ny = {{(CNT_W-7){1'b0}}, cfg.rows_used};
    end
  end

  gbs_div u_div_x (.clk(clk), .en(en), .mag(magx_r), .step(stepx), .quo(quo_x));
  gbs_div u_div_y (.clk(clk), .en(en), .mag(magy_r), .step(stepy), .quo(quo_y));

  assign locx = locate(quo_x, side_r[DIV_STAGES-1].negx, nx);
  assign locy = locate(quo_y, side_r[DIV_STAGES-1].negy, ny);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      vld_r      <= '0;
      p_valid_r  <= 1'b0;
    end else if (en) begin
      s0_valid_r <= start;
      vld_r      <= {vld_r[DIV_STAGES-2:0], s0_valid_r};
      p_valid_r  <= vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side_r.cmd    <= in_command;
      s0_side_r.col    <= in_column;
      s0_side_r.row    <= in_row;
      s0_side_r.height <= in_height;
      s0_side_r.negx   <= dx[32];
      s0_side_r.negy   <= dy[32];
      magx_r           <= adx[MAG_W-1:0];
      magy_r           <= ady[MAG_W-1:0];
      side_r[0]        <= s0_side_r;
      for (int s = 1; s < DIV_STAGES; s++) begin
        side_r[s] <= side_r[s-1];
      end
      p_item_r.cmd    <= side_r[DIV_STAGES-1].cmd;
      p_item_r.col    <= side_r[DIV_STAGES-1].col;
      p_item_r.row    <= side_r[DIV_STAGES-1].row;
      p_item_r.height <= side_r[DIV_STAGES-1].height;
      p_item_r.ix     <= locx.idx;
      p_item_r.iy     <= locy.idx;
      p_item_r.tx     <= locx.frac;
      p_item_r.ty     <= locy.frac;
    end
  end

endmodule

/* rtl/core/gbs_fifo.sv */
// Short queue between front and back end.
// Depends on gbs_pkg for the entry type and depth.
module gbs_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gbs_pkg::q_item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output gbs_pkg::q_item_t head
);
  import gbs_pkg::*;

  q_item_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_PTR_W:0]   count_r;
  logic                  do_pop;

  assign full   = count_r == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign valid  = count_r != '0;
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      priority if (push && !do_pop) begin
        count_r <= count_r + (FIFO_PTR_W+1)'(1);
      end else if (do_pop && !push) begin
        count_r <= count_r - (FIFO_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/core/gbs_back.sv */
// Back end: four grid banks split by column and row parity, weight and
// height products, sum and rounding. Depends on gbs_pkg.
module gbs_back #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid,
  input  gbs_pkg::q_item_t   item,
  output logic               pop,
  output logic               out_valid,
  output logic signed [31:0] out_value
);
  import gbs_pkg::*;

  localparam int CB = (MAX_COLUMNS + 1) / 2;
  localparam int RB = (MAX_ROWS + 1) / 2;
  localparam int BD = CB * RB;
  localparam int AW = (BD > 1) ? $clog2(BD) : 1;

  logic                    wr_en;
  logic [IDX_W-1:0]        wcol;
  logic [IDX_W-1:0]        wrow;
  logic [AW-1:0]           waddr;
  logic signed [18:0]      wx1;
  logic signed [18:0]      wy1;

  logic [15:0]             rd_r [4];
  logic                    b1_valid_r;
  logic                    ix0_r;
  logic                    iy0_r;
  logic signed [18:0]      wx_r [2];
  logic signed [18:0]      wy_r [2];
  logic                    b2_valid_r;
  logic [15:0]             h_r [4];
  logic signed [37:0]      ww_r [4];
  logic                    b3_valid_r;
  logic signed [54:0]      prod_r [4];
  logic                    b4_valid_r;
  logic signed [57:0]      sum_r;
  logic signed [57:0]      rnd;
  logic                    out_valid_r;
  logic signed [31:0]      out_value_r;

  assign pop  = valid;
  assign wcol = {{(IDX_W-6){1'b0}}, item.col};
  assign wrow = {{(IDX_W-6){1'b0}}, item.row};
  assign wr_en = valid && (item.cmd == CMD_WRITE)
              && ({{(CNT_W-6){1'b0}}, item.col} < CNT_W'(MAX_COLUMNS))
              && ({{(CNT_W-6){1'b0}}, item.row} < CNT_W'(MAX_ROWS));
  assign waddr = AW'((wcol >> 1) * RB + (wrow >> 1));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic CP = b[1];
    localparam logic RP = b[0];
    logic [15:0]      mem [BD];
    logic [IDX_W-1:0] csel;
    logic [IDX_W-1:0] rsel;
    logic [AW-1:0]    raddr;
    logic             we;
    assign csel  = (item.ix[0] == CP) ? item.ix : item.ix + IDX_W'(1);
    assign rsel  = (item.iy[0] == RP) ? item.iy : item.iy + IDX_W'(1);
    assign raddr = AW'((csel >> 1) * RB + (rsel >> 1));
    assign we    = wr_en && (item.col[0] == CP) && (item.row[0] == RP);
    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= item.height;
      end
      rd_r[b] <= mem[raddr];
    end
  end

  assign wx1 = {{2{item.tx[FRAC_W-1]}}, item.tx};
  assign wy1 = {{2{item.ty[FRAC_W-1]}}, item.ty};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      b2_valid_r  <= 1'b0;
      b3_valid_r  <= 1'b0;
      b4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b1_valid_r  <= valid && (item.cmd == CMD_QUERY);
      b2_valid_r  <= b1_valid_r;
      b3_valid_r  <= b2_valid_r;
      b4_valid_r  <= b3_valid_r;
      out_valid_r <= b4_valid_r;
    end
  end

  assign rnd = sum_r + (58'sd1 <<< 30);

  always_ff @(posedge clk) begin
    ix0_r   <= item.ix[0];
    iy0_r   <= item.iy[0];
    wx_r[0] <= 19'sd65536 - wx1;
    wx_r[1] <= wx1;
    wy_r[0] <= 19'sd65536 - wy1;
    wy_r[1] <= wy1;
    for (int k = 0; k < 4; k++) begin
      h_r[k]    <= rd_r[{ix0_r ^ k[1], iy0_r ^ k[0]}];
      ww_r[k]   <= wx_r[k[1]] * wy_r[k[0]];
      prod_r[k] <= $signed({1'b0, h_r[k]}) * ww_r[k];
    end
    sum_r <= 58'(prod_r[0]) + 58'(prod_r[1]) + 58'(prod_r[2]) + 58'(prod_r[3]);
    out_value_r <= 32'(rnd >>> 31);
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

/* rtl/core/gbs_check.sv */
// Port-level checks of the grid bilinear sampler, bound to the top level.
// Depends on grid_bilinear_sampler's port list.
module gbs_check (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_command,
  input logic        out_valid,
  input logic        cfg_valid,
  input logic        cfg_ready
);
  localparam int QUERY_LAT = 56;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command |-> ##QUERY_LAT out_valid)
    else $error("query without result at fixed latency");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_command |-> ##QUERY_LAT !out_valid)
    else $error("write produced a result");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration transfer refused");

endmodule

bind grid_bilinear_sampler gbs_check u_gbs_check (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_command(in_command),
  .out_valid(out_valid), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

/* verif/tb_grid_bilinear_sampler.sv */
// Self-checking testbench of grid_bilinear_sampler: heights and point queries
// go in, each query result is compared with a bilinear predictor kept in here.
// Depends on gbs_pkg and the grid_bilinear_sampler RTL.
module tb_grid_bilinear_sampler;
  timeunit 1ns;
  timeprecision 1ps;
  import gbs_pkg::*;

  typedef struct {
    logic        cmd;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [15:0] height;
    logic [31:0] x;
    logic [31:0] y;
  } sampler_cmd_t;

  localparam int NCOL = 64;
  localparam int NROW = 64;
  localparam int FILL_SIZE = 32;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = CMD_WRITE;
  logic [5:0] in_column = '0;
  logic [5:0] in_row = '0;
  logic [15:0] in_height = '0;
  logic signed [31:0] in_x_coord = '0;
  logic signed [31:0] in_y_coord = '0;
  logic out_valid;
  logic signed [31:0] out_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = CFG_X_ORIGIN;
  logic [31:0] cfg_data = '0;

  grid_bilinear_sampler #(.MAX_COLUMNS(NCOL), .MAX_ROWS(NROW)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_column(in_column), .in_row(in_row),
    .in_height(in_height), .in_x_coord(in_x_coord), .in_y_coord(in_y_coord),
    .out_valid(out_valid), .out_value(out_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sampler_cmd_t pending_cmds[$];
  logic signed [31:0] expected_values[$];
  logic [15:0] height_mem [NCOL*NROW];
  logic signed [31:0] x_org = 0, y_org = 0;
  logic [30:0] x_step = 31'd65536, y_step = 31'd65536;
  logic [6:0] col_cnt = 7'd2, row_cnt = 7'd2;
  int idle_pct = 11;
  int mismatches = 0;
  int queries_done = 0, writes_done = 0, cfg_writes = 0;
  int stall_cycles = 0;
  sampler_cmd_t drv_cmd;

  task automatic axis_locate(input longint coord, input logic signed [31:0] org,
                             input logic [30:0] sp, input logic [6:0] cnt,
                             input int maxc, output longint idx, output longint frac);
    longint diff, mag, step, q, n;
    logic neg;
    diff = coord - longint'(org);
    neg  = diff < 0;
    mag  = neg ? -diff : diff;
    step = (sp == 0) ? 1 : longint'(sp);
    q    = (mag << 16) / step;
    n    = (cnt < 2) ? 2 : ((cnt > maxc) ? maxc : cnt);
    idx  = q >> 16;
    frac = q & 64'hFFFF;
    if (neg) begin
      idx = -idx;
      frac = -frac;
    end
    if (idx < 0) begin
      idx = 0;
      frac = 0;
    end
    if (idx + 1 >= n) begin
      idx = n - 2;
      frac = 0;
    end
  endtask

  task automatic predict_value(input sampler_cmd_t c, output logic signed [31:0] v);
    longint ix, tx, iy, ty, wx0, wy0, acc, r;
    axis_locate(longint'($signed(c.x)), x_org, x_step, col_cnt, NCOL, ix, tx);
    axis_locate(longint'($signed(c.y)), y_org, y_step, row_cnt, NROW, iy, ty);
    wx0 = 65536 - tx;
    wy0 = 65536 - ty;
    acc = longint'(height_mem[ix*NROW + iy]) * (wx0 * wy0)
        + longint'(height_mem[(ix+1)*NROW + iy]) * (tx * wy0)
        + longint'(height_mem[ix*NROW + iy + 1]) * (wx0 * ty)
        + longint'(height_mem[(ix+1)*NROW + iy + 1]) * (tx * ty);
    r = (acc + (longint'(1) << 30)) >>> 31;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    v = r[31:0];
  endtask

  function automatic logic [31:0] grid_coord(logic signed [31:0] org, logic [30:0] sp,
                                             logic [6:0] cnt);
    longint c;
    c = longint'(org) + (longint'($urandom_range(cnt * 1024 + 512)) * longint'(sp)) / 1024
        - longint'(sp) / 4;
    if (c > 64'sd2147483647) c = 64'sd2147483647;
    if (c < -64'sd2147483648) c = -64'sd2147483648;
    return c[31:0];
  endfunction

  function automatic sampler_cmd_t make_cmd(logic cmd, logic [5:0] col, logic [5:0] row,
                                            logic [15:0] h, logic [31:0] x, logic [31:0] y);
    sampler_cmd_t c;
    c.cmd = cmd; c.col = col; c.row = row; c.height = h; c.x = x; c.y = y;
    return c;
  endfunction

  // driver: hold the item while busy, record writes and predict queries at each transfer
  always @(posedge clk) begin
    logic signed [31:0] v;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (drv_cmd.cmd == CMD_WRITE) begin
          height_mem[drv_cmd.col*NROW + drv_cmd.row] = drv_cmd.height;
          writes_done++;
        end else begin
          predict_value(drv_cmd, v);
          expected_values.push_back(v);
          queries_done++;
        end
      end
      if (!(start && busy)) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
          drv_cmd = pending_cmds.pop_front();
          start <= 1'b1;
          in_command <= drv_cmd.cmd;
          in_column <= drv_cmd.col;
          in_row <= drv_cmd.row;
          in_height <= drv_cmd.height;
          in_x_coord <= drv_cmd.x;
          in_y_coord <= drv_cmd.y;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic signed [31:0] want;
    if (rst_n && out_valid) begin
      if (expected_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%0d", out_value);
      end else begin
        want = expected_values.pop_front();
        if (out_value !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("value mismatch: expected %0d actual %0d", want, out_value);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_X_ORIGIN:  x_org = data;
      CFG_X_SPACING: x_step = data[30:0];
      CFG_Y_ORIGIN:  y_org = data;
      CFG_Y_SPACING: y_step = data[30:0];
      CFG_COLUMNS:   col_cnt = data[6:0];
      CFG_ROWS:      row_cnt = data[6:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic [31:0] xo, input logic [30:0] xs, input logic [31:0] yo,
                          input logic [30:0] ys, input logic [6:0] nc, input logic [6:0] nr);
    write_reg(CFG_X_ORIGIN, xo);
    write_reg(CFG_X_SPACING, {1'b0, xs});
    write_reg(CFG_Y_ORIGIN, yo);
    write_reg(CFG_Y_SPACING, {1'b0, ys});
    write_reg(CFG_COLUMNS, {25'd0, nc});
    write_reg(CFG_ROWS, {25'd0, nr});
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || start || expected_values.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(input int count);
    int k;
    logic [15:0] h;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < 30) begin
        h = ($urandom_range(9) == 0) ? 16'd32768 : 16'($urandom_range(32768));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 6'($urandom), 6'($urandom), h,
                                        $urandom, $urandom));
      end else if ($urandom_range(99) < 80) begin
        pending_cmds.push_back(make_cmd(CMD_QUERY, 6'($urandom), 6'($urandom), 16'($urandom),
                                        grid_coord(x_org, x_step, col_cnt),
                                        grid_coord(y_org, y_step, row_cnt)));
      end else begin
        pending_cmds.push_back(make_cmd(CMD_QUERY, 6'($urandom), 6'($urandom), 16'($urandom),
                                        $urandom, $urandom));
      end
    end
  endtask

  initial begin
    int c, r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // fill the corner of the grid that grids of up to FILL_SIZE lines can read
    for (c = 0; c < FILL_SIZE; c++)
      for (r = 0; r < FILL_SIZE; r++)
        pending_cmds.push_back(make_cmd(CMD_WRITE, 6'(c), 6'(r),
                                        16'($urandom_range(32768)), '0, '0));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 6'd0, 6'd0, 16'd32768, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 6'd63, 6'd63, 16'd0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 6'd1, 6'd1, 16'd32768, '0, '0));
    drain();

    // directed, reset geometry
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 32'h0000_0000, 32'h0000_0000));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 32'h0000_8000, 32'h0000_4000));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_8000));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 32'hFFFF_0000, 32'h0000_0000));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 32'h0001_0000, 32'h0000_FFFF));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 6'd0, 6'd1, 16'hFFFF, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 32'h0000_4000, 32'hFFFF_C000));
    drain();

    // largest filled grid, shifted origin
    set_grid(32'hFFFE_0000, 31'd65536, 32'h0003_0000, 31'd98304, 7'(FILL_SIZE),
             7'(FILL_SIZE));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 32'h003D_FFFF, 32'h0063_0000));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 32'h003E_0000, 32'h0002_FFFF));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 32'hFFFD_8000, 32'h0000_0000));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 32'h0010_1234, 32'h0020_ABCD));
    idle_pct = 11;
    queue_random(200);
    drain();

    // extreme geometry
    set_grid(32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1, 7'd2, 7'(FILL_SIZE));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 32'h0000_0000, 32'h7FFF_FFFE));
    idle_pct = 86;
    queue_random(150);
    drain();

    idle_pct = 0;
    repeat (4) begin
      set_grid($urandom, 31'($urandom_range(32'h7FFF_FFFF, 1)), $urandom,
               31'($urandom_range(32'h0004_0000, 1)), 7'($urandom_range(FILL_SIZE, 0)),
               7'($urandom_range(FILL_SIZE, 0)));
      queue_random(40);
      drain();
    end

    $display("covered %0d queries and %0d height writes under %0d register writes",
             queries_done, writes_done, cfg_writes);
    $display("sender idling at 11%%, 86%% and 0%%; reset, extreme and random geometry");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/core/gbs_pkg.sv
rtl/core/gbs_div.sv
rtl/core/gbs_front.sv
rtl/core/gbs_fifo.sv
rtl/core/gbs_back.sv
rtl/core/grid_bilinear_sampler.sv
rtl/core/gbs_check.sv
verif/tb_grid_bilinear_sampler.sv
